>>> rtl/core/roman_numeral_encoder_top_assert.svh
// Assertion macros for the encoder modules.
// Each macro takes a label, the clock, the reset, a trigger and a consequence.
`ifndef ROMAN_NUMERAL_ENCODER_TOP_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define RNE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rne: same-cycle check failed");

// Next-cycle implication.
`define RNE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rne: next-cycle check failed");

`else

`define RNE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RNE_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/rne_pkg.sv
`timescale 1ns / 1ps

package rne_pkg;

   localparam int VALUE_W    = 12;
   localparam int SYMBOL_W   = 7;
   localparam int WEIGHT_W   = 10;
   localparam int STEP_IDX_W = 4;
   localparam int NUM_STEPS  = 13;

   // Clearing this bit turns a lower-case ASCII letter into a capital.
   localparam logic [SYMBOL_W-1:0] CASE_BIT = 7'h20;

   localparam logic [SYMBOL_W-1:0] LETTER_NONE = 7'h00;
   localparam logic [SYMBOL_W-1:0] LETTER_M    = 7'h6d;
   localparam logic [SYMBOL_W-1:0] LETTER_D    = 7'h64;
   localparam logic [SYMBOL_W-1:0] LETTER_C    = 7'h63;
   localparam logic [SYMBOL_W-1:0] LETTER_L    = 7'h6c;
   localparam logic [SYMBOL_W-1:0] LETTER_X    = 7'h78;
   localparam logic [SYMBOL_W-1:0] LETTER_V    = 7'h76;
   localparam logic [SYMBOL_W-1:0] LETTER_I    = 7'h69;

   typedef enum logic {
      ST_IDLE,
      ST_CONVERT
   } state_type;

   typedef struct packed {
      logic load;     // take the accepted number into the datapath
      logic advance;  // produce the next character into the output register
   } cmd_type;

   typedef struct packed {
      logic last_char;  // the character being produced ends the numeral
   } status_type;

   function automatic logic [WEIGHT_W-1:0] step_weight(input logic [STEP_IDX_W-1:0] idx);
      logic [WEIGHT_W-1:0] w;
      unique case (idx)
         4'd0:    w = 10'd1000;
         4'd1:    w = 10'd900;
         4'd2:    w = 10'd500;
         4'd3:    w = 10'd400;
         4'd4:    w = 10'd100;
         4'd5:    w = 10'd90;
         4'd6:    w = 10'd50;
         4'd7:    w = 10'd40;
         4'd8:    w = 10'd10;
         4'd9:    w = 10'd9;
         4'd10:   w = 10'd5;
         4'd11:   w = 10'd4;
         4'd12:   w = 10'd1;
         default: w = 10'd1;
      endcase
      return w;
   endfunction

   function automatic logic [SYMBOL_W-1:0] step_first(input logic [STEP_IDX_W-1:0] idx);
      logic [SYMBOL_W-1:0] c;
      unique case (idx)
         4'd0:    c = LETTER_M;
         4'd1:    c = LETTER_C;
         4'd2:    c = LETTER_D;
         4'd3:    c = LETTER_C;
         4'd4:    c = LETTER_C;
         4'd5:    c = LETTER_X;
         4'd6:    c = LETTER_L;
         4'd7:    c = LETTER_X;
         4'd8:    c = LETTER_X;
         4'd9:    c = LETTER_I;
         4'd10:   c = LETTER_V;
         4'd11:   c = LETTER_I;
         4'd12:   c = LETTER_I;
         default: c = LETTER_I;
      endcase
      return c;
   endfunction

   // Second letter of a subtractive pair, LETTER_NONE for single letters.
   function automatic logic [SYMBOL_W-1:0] step_second(input logic [STEP_IDX_W-1:0] idx);
      logic [SYMBOL_W-1:0] c;
      unique case (idx)
         4'd1:    c = LETTER_M;
         4'd3:    c = LETTER_D;
         4'd5:    c = LETTER_C;
         4'd7:    c = LETTER_L;
         4'd9:    c = LETTER_X;
         4'd11:   c = LETTER_V;
         default: c = LETTER_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [SYMBOL_W-1:0] apply_case(input logic [SYMBOL_W-1:0] c,
                                                     input logic upper);
      return upper ? (c & ~CASE_BIT) : c;
   endfunction

endpackage

>>> rtl/core/rne_req_if.sv
`timescale 1ns / 1ps

interface rne_req_if;
   logic                          valid;
   logic                          ready;
   logic [rne_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/core/rne_rsp_if.sv
`timescale 1ns / 1ps

interface rne_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rne_pkg::SYMBOL_W-1:0]  symbol;
   logic                          last;
   logic                          empty_res;

   modport source (output valid, output symbol, output last, output empty_res, input ready);
   modport sink   (input valid, input symbol, input last, input empty_res, output ready);
endinterface

>>> rtl/core/roman_numeral_encoder_top.sv
`timescale 1ns / 1ps
// Roman numeral encoder.
// req_bus carries one 12-bit unsigned number per beat; rsp_bus returns the
// numeral one ASCII letter per beat, with last set on the final letter of
// each number. A zero input gives a single beat with symbol 0, last and
// empty_res set. csr_wr_en/csr_wr_data write the upper_case bit (1 gives
// capitals); write it only while the block is idle.
// Flow: a number is taken in the idle state and registered into the
// datapath; its letters then enter the output register and show on rsp_bus,
// one beat per cycle while rsp_bus.ready stays high. A numeral has 1 to 15
// letters; the single output register takes one letter per cycle unless the
// receiver stalls, and a new number is taken only in the idle state.
// Subtractive pairs (cm, cd, xc, xl, ix, iv) take two beats each.
// Reset clears the controller to idle, empties the output register and sets
// upper_case to 0. When the receiver holds rsp_bus.ready low, the waiting
// beat stays put and conversion pauses; req_bus.ready stays low until the
// last letter of the current number has entered the output register.

module roman_numeral_encoder_top (
   input  logic       clock,
   input  logic       reset,
   rne_req_if.sink    req_bus,
   rne_rsp_if.source  rsp_bus,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import rne_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // Sequencer: owns the handshakes and decides when the datapath steps.
   rne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath: remaining number, pending pair letter, output register.
   rne_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_value     (req_bus.value),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_symbol    (rsp_bus.symbol),
      .rsp_last      (rsp_bus.last),
      .rsp_empty_res (rsp_bus.empty_res)
   );

endmodule

>>> rtl/core/rne_ctrl.sv
`timescale 1ns / 1ps
`include "roman_numeral_encoder_top_assert.svh"

module rne_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output rne_pkg::cmd_type     cmd,
   input  rne_pkg::status_type  sts
);
   import rne_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (cmd.advance && sts.last_char) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONVERT: begin
            // advance only when the output register is free or drains now
            cmd.advance = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.advance) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   `RNE_ASSERT_NXT(a_load_enters_convert, clock, reset, cmd.load, state_ff == ST_CONVERT)
   `RNE_ASSERT_NXT(a_final_beat_idles, clock, reset, cmd.advance && sts.last_char, state_ff == ST_IDLE)
   `RNE_ASSERT_NXT(a_advance_fills_output, clock, reset, cmd.advance, rsp_valid_ff)

endmodule

>>> rtl/core/rne_datapath.sv
`timescale 1ns / 1ps

module rne_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  rne_pkg::cmd_type              cmd,
   output rne_pkg::status_type           sts,
   input  logic [rne_pkg::VALUE_W-1:0]   req_value,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   output logic [rne_pkg::SYMBOL_W-1:0]  rsp_symbol,
   output logic                          rsp_last,
   output logic                          rsp_empty_res
);
   import rne_pkg::*;

   logic                  upper_ff;
   logic [VALUE_W-1:0]    num_ff, num_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [SYMBOL_W-1:0]   pend_sym_ff, pend_sym_in;
   logic [SYMBOL_W-1:0]   sym_ff, sym_in;
   logic                  last_ff, last_in;
   logic                  empty_ff, empty_in;

   logic [STEP_IDX_W-1:0] idx;
   logic [VALUE_W-1:0]    weight;
   logic [VALUE_W-1:0]    diff;
   logic [SYMBOL_W-1:0]   second;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff    <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) upper_ff <= csr_wr_data;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      pend_sym_ff <= pend_sym_in;
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      empty_ff    <= empty_in;
   end

   // Largest weight not above the remaining number.
   always_comb begin
      idx = STEP_IDX_W'(NUM_STEPS - 1);
      for (int k = NUM_STEPS - 1; k >= 0; k--) begin
         if (num_ff >= VALUE_W'(step_weight(STEP_IDX_W'(k)))) idx = STEP_IDX_W'(k);
      end
      weight = VALUE_W'(step_weight(idx));
      diff   = num_ff - weight;
      second = step_second(idx);
   end

   always_comb begin
      num_in      = num_ff;
      pend_vld_in = pend_vld_ff;
      pend_sym_in = pend_sym_ff;
      sym_in      = sym_ff;
      last_in     = last_ff;
      empty_in    = empty_ff;
      sts.last_char = 1'b0;

      priority if (pend_vld_ff) begin
         sts.last_char = (num_ff == '0);
      end else if (num_ff == '0) begin
         sts.last_char = 1'b1;
      end else begin
         sts.last_char = (second == LETTER_NONE) && (diff == '0);
      end

      if (cmd.load) begin
         num_in      = req_value;
         pend_vld_in = 1'b0;
      end else if (cmd.advance) begin
         last_in  = sts.last_char;
         empty_in = 1'b0;
         priority if (pend_vld_ff) begin
            // second letter of a subtractive pair
            sym_in      = apply_case(pend_sym_ff, upper_ff);
            pend_vld_in = 1'b0;
         end else if (num_ff == '0) begin
            // zero input: one empty beat
            sym_in   = LETTER_NONE;
            empty_in = 1'b1;
         end else begin
            sym_in      = apply_case(step_first(idx), upper_ff);
            num_in      = diff;
            pend_vld_in = (second != LETTER_NONE);
            pend_sym_in = second;
         end
      end
   end

   assign rsp_symbol    = sym_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_ff;

endmodule

>>> tb/sv/tb_roman_numeral_encoder_top.sv
`timescale 1ns / 1ps

module tb_roman_numeral_encoder_top;
   import rne_pkg::*;

   // Abandon the run after this many cycles in which no beat moves on either channel.
   localparam int STUCK_LIMIT = 2000;
   // Extra cycles to watch the result channel once nothing is pending.
   localparam int SETTLE_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
      logic                empty_res;
   } letter_beat_type;

   // Holds the letters each accepted number must produce, oldest first.
   class numeral_board;
      letter_beat_type pending_letters[$];
      int unsigned     misses;

      function void report(string msg);
         misses++;
         if (misses <= REPORT_LIMIT) $display("ERROR: %s", msg);
      endfunction

      // Spell the number greedily over the weights; pairs give two letters.
      function void note_number(logic [VALUE_W-1:0] value, logic upper);
         int unsigned         weight[13];
         logic [SYMBOL_W-1:0] lead[13];
         logic [SYMBOL_W-1:0] trail[13];
         int unsigned         rest;
         letter_beat_type     beat;
         weight = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
         lead   = '{LETTER_M, LETTER_C, LETTER_D, LETTER_C, LETTER_C, LETTER_X, LETTER_L,
                    LETTER_X, LETTER_X, LETTER_I, LETTER_V, LETTER_I, LETTER_I};
         trail  = '{LETTER_NONE, LETTER_M, LETTER_NONE, LETTER_D, LETTER_NONE, LETTER_C,
                    LETTER_NONE, LETTER_L, LETTER_NONE, LETTER_X, LETTER_NONE, LETTER_V,
                    LETTER_NONE};
         if (value == '0) begin
            beat = '{symbol: LETTER_NONE, last: 1'b1, empty_res: 1'b1};
            pending_letters.push_back(beat);
            return;
         end
         rest = 32'(value);
         for (int s = 0; s < 13; s++) begin
            while (rest >= weight[s]) begin
               beat = '{symbol: upper ? (lead[s] & ~CASE_BIT) : lead[s],
                        last: 1'b0, empty_res: 1'b0};
               pending_letters.push_back(beat);
               if (trail[s] != LETTER_NONE) begin
                  beat.symbol = upper ? (trail[s] & ~CASE_BIT) : trail[s];
                  pending_letters.push_back(beat);
               end
               rest -= weight[s];
            end
         end
         pending_letters[pending_letters.size() - 1].last = 1'b1;
      endfunction

      function void check_letter(logic [SYMBOL_W-1:0] symbol, logic last, logic empty_res);
         letter_beat_type want;
         if (pending_letters.size() == 0) begin
            report($sformatf("result beat with no number pending: symbol=%h last=%b empty=%b",
                             symbol, last, empty_res));
            return;
         end
         want = pending_letters.pop_front();
         if (symbol !== want.symbol || last !== want.last || empty_res !== want.empty_res)
            report($sformatf("expected symbol=%h last=%b empty=%b, got symbol=%h last=%b empty=%b",
                             want.symbol, want.last, want.empty_res, symbol, last, empty_res));
      endfunction

      function int outstanding();
         return pending_letters.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   rne_req_if req_bus ();
   rne_rsp_if rsp_bus ();

   roman_numeral_encoder_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   numeral_board board = new();

   // Local copy of the case select, used when predicting each number.
   logic upper_sel = 1'b0;
   // Percent of cycles in which the sender holds back or the receiver stalls.
   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned stuck_cycles = 0;

   // Numbers that hit every weight, every pair, the longest numeral and both bit extremes.
   logic [VALUE_W-1:0] directed_values[$] = '{
      12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd40, 12'd50, 12'd90, 12'd400, 12'd500,
      12'd900, 12'd1000, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2730, 12'd1365,
      12'd2048, 12'd444, 12'd949, 12'd3
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Drive every input to a known value before the first edge.
   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
   end

   // Stall the result channel at random, at the rate the current phase asks.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watch both channels: predict each accepted number, check each accepted letter,
   // and count the cycles in which nothing moves.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) board.note_number(req_bus.value, upper_sel);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_letter(rsp_bus.symbol, rsp_bus.last, rsp_bus.empty_res);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stuck_cycles <= 0;
         else
            stuck_cycles <= stuck_cycles + 1;
      end
   end

   // End the run when the channels stay quiet for too long.
   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // Write the case select; only called while the block is idle.
   task write_case_select(input logic upper);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= upper;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      upper_sel    = upper;
   endtask

   // Offer one number, holding back at random first; return at the accepting edge.
   task send_number(input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and wait until every predicted letter has arrived.
   task drain_letters();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (board.outstanding() != 0);
      @(posedge clock);
   endtask

   // Favor zero, small numbers and long numerals, otherwise draw uniformly.
   function automatic logic [VALUE_W-1:0] pick_number();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 6) return '0;
      if (roll < 20) return VALUE_W'($urandom_range(4095, 3000));
      if (roll < 30) return VALUE_W'($urandom_range(20, 1));
      return VALUE_W'($urandom_range(4095, 0));
   endfunction

   task random_phase(input int count, input int unsigned send_pct, input int unsigned recv_pct,
                     input logic upper);
      write_case_select(upper);
      send_gap_pct   = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) send_number(pick_number());
      drain_letters();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed numbers in lower case, then the edge cases again in capitals.
      write_case_select(1'b0);
      send_gap_pct   = 11;
      recv_stall_pct = 48;
      foreach (directed_values[i]) send_number(directed_values[i]);
      drain_letters();
      write_case_select(1'b1);
      send_number(12'd0);
      send_number(12'd3888);
      send_number(12'd4095);
      drain_letters();

      // Random numbers: receiver lean then sender lean, then full rate both ways.
      random_phase(85, 11, 48, 1'b0);
      random_phase(85, 48, 11, 1'b1);
      random_phase(85, 0, 0, 1'b0);

      // Hold for SETTLE_CYCLES to catch any stray letter after the last one.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.misses == 0 && board.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
